// ===== hw/rtl/sharpe_sortino_ratio_assert.svh =====
// Assertion macros shared by the RTL of the Sharpe/Sortino unit.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef SHARPE_SORTINO_RATIO_ASSERT_SVH
`define SHARPE_SORTINO_RATIO_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ssr_pkg.sv =====
// Shared types and constants for the Sharpe/Sortino ratio unit.
// No dependencies.
package ssr_pkg;

    localparam int COUNT_BITS  = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};
    localparam logic [15:0] PERIODS_RESET = 16'd252;

    localparam logic CFG_RISK_FREE = 1'b0;
    localparam logic CFG_PERIODS   = 1'b1;

    typedef struct packed {
        logic signed [31:0] return_sample;
        logic               last_sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] sharpe_ratio;
        logic signed [31:0] sortino_ratio;
        logic [15:0]        samples_seen;
        logic               count_overflow;
    } out_beat_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] sample_total;
        logic signed [47:0]    return_sum;
        logic [63:0]           square_sum;
        logic [COUNT_BITS-1:0] loss_total;
        logic [63:0]           loss_square_sum;
        logic                  overflow_seen;
    } acc_status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ACC,
        CS_CALC,
        CS_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        ST_MEAN,
        ST_RFP,
        ST_MSQ,
        ST_SUB,
        ST_DEV,
        ST_SD,
        ST_RP,
        ST_LDIV,
        ST_RMS,
        ST_NUM,
        ST_QSH,
        ST_QSO
    } step_t;

endpackage

// ===== hw/rtl/ssr_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, 48 x 33 -> 64 bits.
// Depends on nothing; used by ssr_accum and the top level.
module ssr_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] mcand,
    input  logic [32:0] mplier,
    output logic [63:0] product,
    output logic        done,
    output logic        busy
);
    logic [63:0] acc_reg;
    logic [63:0] mcand_reg;
    logic [32:0] mplier_reg;
    logic        busy_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && mplier_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {16'b0, mcand};
            mplier_reg <= mplier;
        end
        else if (busy_reg && mplier_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[62:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[32:1]};
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;
    assign busy    = busy_reg;
endmodule

// ===== hw/rtl/ssr_div.sv =====
// Restoring divider, one quotient bit per cycle, 64 / 48 -> 64 bits.
// Depends on nothing; used by the top level.
module ssr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic [63:0] quotient,
    output logic        done,
    output logic        busy
);
    logic [63:0] work_reg;
    logic [47:0] rem_reg;
    logic [47:0] dvs_reg;
    logic [5:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [48:0] trial;
    logic [48:0] diff;
    logic        qbit;

    assign trial = {rem_reg, work_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= 6'd63;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 6'd1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= qbit ? diff[47:0] : trial[47:0];
            work_reg <= {work_reg[62:0], qbit};
        end
    end

    assign quotient = work_reg;
    assign done     = done_reg;
    assign busy     = busy_reg;
endmodule

// ===== hw/rtl/ssr_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on nothing; used by the top level.
module ssr_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic [31:0] root,
    output logic        done,
    output logic        busy
);
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic        take;

    assign shifted = {rem_reg, rad_reg[63:62]};
    assign trial   = {2'b0, root_reg, 2'b01};
    assign take    = (shifted >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= 5'd31;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 5'd1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below 2*root+1, so 34 bits hold it
            rem_reg  <= take ? 34'(shifted - trial) : shifted[33:0];
            root_reg <= {root_reg[30:0], take};
            rad_reg  <= {rad_reg[61:0], 2'b00};
        end
    end

    assign root = root_reg;
    assign done = done_reg;
    assign busy = busy_reg;
endmodule

// ===== hw/rtl/ssr_accum.sv =====
// Series accumulators: count, sum, sum of squares, loss count and loss squares.
// Depends on ssr_pkg and ssr_mul (serial squaring).
module ssr_accum (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [31:0]     sample,
    input  logic                   clear,
    output ssr_pkg::acc_status_t   status,
    output logic                   done
);
    import ssr_pkg::*;

    acc_status_t acc_reg;
    logic        pending_reg;
    logic        neg_reg;
    logic signed [31:0] sample_reg;
    logic        done_reg;
    logic [31:0] mag;
    logic [63:0] product;
    logic        mul_done;
    logic        mul_busy;
    logic        full;
    logic [47:0] sq;

    assign mag  = sample[31] ? 32'd0 - sample : sample;
    assign full = (acc_reg.sample_total == COUNT_LIMIT);
    assign sq   = product[63:16];

    ssr_mul u_sq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start && !full),
        .mcand  ({16'b0, mag}),
        .mplier ({1'b0, mag}),
        .product(product),
        .done   (mul_done),
        .busy   (mul_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (start && full)
            begin
                // counter full: drop the sample, flag it
                acc_reg.overflow_seen <= 1'b1;
                done_reg <= 1'b1;
            end
            else if (start)
            begin
                pending_reg <= 1'b1;
            end
            else if (pending_reg && mul_done)
            begin
                pending_reg          <= 1'b0;
                done_reg             <= 1'b1;
                acc_reg.sample_total <= acc_reg.sample_total + COUNT_BITS'(1);
                acc_reg.return_sum   <= acc_reg.return_sum + 48'(sample_reg);
                acc_reg.square_sum   <= acc_reg.square_sum + {16'b0, sq};
                if (neg_reg)
                begin
                    acc_reg.loss_total      <= acc_reg.loss_total + COUNT_BITS'(1);
                    acc_reg.loss_square_sum <= acc_reg.loss_square_sum + {16'b0, sq};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_reg <= sample;
            neg_reg    <= sample[31];
        end
    end

    assign status = acc_reg;
    assign done   = done_reg && !mul_busy;
endmodule

// ===== hw/rtl/sharpe_sortino_ratio.sv =====
// Top level of the annualized Sharpe/Sortino ratio unit: control and back end.
// Depends on ssr_pkg, ssr_accum, ssr_mul, ssr_div, ssr_sqrt and the assert header.
//
//   channel   dir  handshake                    payload
//   sample    in   sample_valid/sample_ready    ssr_pkg::in_beat_t
//   result    out  result_valid/result_ready    ssr_pkg::out_beat_t
//   cfg       in   cfg_we                       cfg_index, cfg_data
//
// A sample beat is held from accept to the next accept while the serial
// squarer runs one bit per cycle and stops early on the top zero bits of the
// magnitude. A beat dropped at a full counter skips the squarer.
// A last beat adds the back end: up to six divides, three roots and three
// serial multiplies, run one at a time on the shared units.
// Reset clears all accumulators and sets periods_per_year to 252.
// A finished result waits in the output register; samples are taken meanwhile,
// and only the next result waits for it to drain.
`include "sharpe_sortino_ratio_assert.svh"

module sharpe_sortino_ratio (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  ssr_pkg::in_beat_t   sample,
    output logic                result_valid,
    input  logic                result_ready,
    output ssr_pkg::out_beat_t  result,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import ssr_pkg::*;

    ctrl_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    logic        launched_reg, launched_next;
    logic        last_reg;

    logic signed [31:0] rf_reg;
    logic [15:0]        p_reg;

    acc_status_t acc;
    logic        acc_start;
    logic        acc_done;
    logic        acc_clear;

    logic        unit_start;
    logic        unit_done;
    logic        div_start, mul_start, sqrt_start;
    logic        div_done, mul_done, sqrt_done;
    logic        div_busy, mul_busy, sqrt_busy;
    logic [63:0] div_dividend, div_q;
    logic [47:0] div_divisor;
    logic [47:0] mul_mcand;
    logic [32:0] mul_mplier;
    logic [63:0] mul_p;
    logic [63:0] sqrt_rad;
    logic [31:0] sqrt_root;

    logic [31:0] mm_reg;
    logic        m_neg_reg;
    logic [31:0] rfp_reg;
    logic [63:0] mm2_reg;
    logic [63:0] sub_reg;
    logic [63:0] tmp_reg;
    logic [31:0] sd_reg;
    logic [31:0] rootp_reg;
    logic [31:0] rms_reg;
    logic [63:0] num_reg;
    logic [31:0] sharpe_reg;
    logic [31:0] sortino_reg;

    out_beat_t   result_reg;
    logic        result_valid_reg;
    logic        out_load;

    logic [15:0] p_eff;
    logic [47:0] sum_mag;
    logic [31:0] rf_mag;
    logic [33:0] m_ext, rfp_ext, m_s, rfp_s, excess, ex_abs;
    logic        ex_neg;
    logic [63:0] devsq;
    logic        is_div, is_mul, is_sqrt;

    function automatic logic [31:0] sat_q16(input logic [63:0] q, input logic neg);
        logic [31:0] r;
        begin
            if (neg)
            begin
                r = (q > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
            end
            else
            begin
                r = (q > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            end
            return r;
        end
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg <= '0;
            p_reg  <= PERIODS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RISK_FREE: rf_reg <= cfg_data;
                CFG_PERIODS:   p_reg  <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // ---------------- accumulators ----------------
    ssr_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .start (acc_start),
        .sample(sample.return_sample),
        .clear (acc_clear),
        .status(acc),
        .done  (acc_done)
    );

    // ---------------- shared back-end units ----------------
    ssr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .quotient(div_q),
        .done    (div_done),
        .busy    (div_busy)
    );

    ssr_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .product(mul_p),
        .done   (mul_done),
        .busy   (mul_busy)
    );

    ssr_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .radicand(sqrt_rad),
        .root    (sqrt_root),
        .done    (sqrt_done),
        .busy    (sqrt_busy)
    );

    // ---------------- datapath terms ----------------
    assign p_eff   = (p_reg == '0) ? 16'd1 : p_reg;
    assign sum_mag = acc.return_sum[47] ? 48'd0 - acc.return_sum : acc.return_sum;
    assign rf_mag  = rf_reg[31] ? 32'd0 - rf_reg : rf_reg;
    assign m_ext   = {2'b0, mm_reg};
    assign rfp_ext = {2'b0, rfp_reg};
    assign m_s     = m_neg_reg ? 34'd0 - m_ext : m_ext;
    assign rfp_s   = rf_reg[31] ? 34'd0 - rfp_ext : rfp_ext;
    assign excess  = m_s - rfp_s;
    assign ex_neg  = excess[33];
    assign ex_abs  = ex_neg ? 34'd0 - excess : excess;
    assign devsq   = (acc.square_sum > sub_reg) ? acc.square_sum - sub_reg : 64'd0;

    always_comb
    begin
        is_div  = 1'b0;
        is_mul  = 1'b0;
        is_sqrt = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_mcand    = '0;
        mul_mplier   = '0;
        sqrt_rad     = '0;
        case (step_reg)
            ST_MEAN:
            begin
                is_div       = 1'b1;
                div_dividend = {16'b0, sum_mag};
                div_divisor  = 48'(acc.sample_total);
            end
            ST_RFP:
            begin
                is_div       = 1'b1;
                div_dividend = {32'b0, rf_mag};
                div_divisor  = {32'b0, p_eff};
            end
            ST_MSQ:
            begin
                is_mul     = 1'b1;
                mul_mcand  = {16'b0, mm_reg};
                mul_mplier = {1'b0, mm_reg};
            end
            ST_SUB:
            begin
                is_mul     = 1'b1;
                mul_mcand  = mm2_reg[63:16];
                mul_mplier = 33'(acc.sample_total);
            end
            ST_DEV:
            begin
                is_div       = 1'b1;
                div_dividend = devsq;
                div_divisor  = 48'(acc.sample_total) - 48'd1;
            end
            ST_SD:
            begin
                is_sqrt  = 1'b1;
                sqrt_rad = tmp_reg;
            end
            ST_RP:
            begin
                is_sqrt  = 1'b1;
                sqrt_rad = {16'b0, p_eff, 32'b0};
            end
            ST_LDIV:
            begin
                is_div       = 1'b1;
                div_dividend = acc.loss_square_sum;
                div_divisor  = 48'(acc.loss_total);
            end
            ST_RMS:
            begin
                is_sqrt  = 1'b1;
                sqrt_rad = tmp_reg;
            end
            ST_NUM:
            begin
                is_mul     = 1'b1;
                mul_mcand  = {16'b0, rootp_reg};
                mul_mplier = ex_abs[32:0];
            end
            ST_QSH:
            begin
                is_div       = 1'b1;
                div_dividend = num_reg;
                div_divisor  = {8'b0, sd_reg, 8'b0};
            end
            ST_QSO:
            begin
                is_div       = 1'b1;
                div_dividend = num_reg;
                div_divisor  = {8'b0, rms_reg, 8'b0};
            end
            default: ;
        endcase
    end

    assign unit_done = div_done || mul_done || sqrt_done;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        launched_next = launched_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = CS_ACC;
                end
            end
            CS_ACC:
            begin
                if (acc_done)
                begin
                    if (!last_reg)
                    begin
                        state_next = CS_IDLE;
                    end
                    else if (acc.sample_total < 2)
                    begin
                        state_next = CS_OUT;
                    end
                    else
                    begin
                        state_next    = CS_CALC;
                        step_next     = ST_MEAN;
                        launched_next = 1'b0;
                    end
                end
            end
            CS_CALC:
            begin
                if (!launched_reg)
                begin
                    launched_next = 1'b1;
                end
                else if (unit_done)
                begin
                    launched_next = 1'b0;
                    case (step_reg)
                        ST_MEAN: step_next = ST_RFP;
                        ST_RFP:  step_next = ST_MSQ;
                        ST_MSQ:  step_next = ST_SUB;
                        ST_SUB:  step_next = ST_DEV;
                        ST_DEV:  step_next = ST_SD;
                        ST_SD:   step_next = ST_RP;
                        ST_RP:   step_next = (acc.loss_total == '0) ? ST_NUM : ST_LDIV;
                        ST_LDIV: step_next = ST_RMS;
                        ST_RMS:  step_next = ST_NUM;
                        ST_NUM:
                        begin
                            // a zero deviation leaves its ratio at zero
                            if (sd_reg != '0)
                            begin
                                step_next = ST_QSH;
                            end
                            else if (rms_reg != '0)
                            begin
                                step_next = ST_QSO;
                            end
                            else
                            begin
                                state_next = CS_OUT;
                            end
                        end
                        ST_QSH:
                        begin
                            if (rms_reg != '0)
                            begin
                                step_next = ST_QSO;
                            end
                            else
                            begin
                                state_next = CS_OUT;
                            end
                        end
                        ST_QSO:  state_next = CS_OUT;
                        default: state_next = CS_OUT;
                    endcase
                end
            end
            CS_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // ---------------- outputs of the control ----------------
    always_comb
    begin
        sample_ready = (state_reg == CS_IDLE);
        acc_start    = sample_valid && (state_reg == CS_IDLE);
        unit_start   = (state_reg == CS_CALC) && !launched_reg;
        div_start    = unit_start && is_div;
        mul_start    = unit_start && is_mul;
        sqrt_start   = unit_start && is_sqrt;
        out_load     = (state_reg == CS_OUT) && (!result_valid_reg || result_ready);
        acc_clear    = out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= CS_IDLE;
            step_reg         <= ST_MEAN;
            launched_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            launched_reg <= launched_next;
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- back-end result capture ----------------
    always_ff @(posedge clk)
    begin
        if (acc_start)
        begin
            last_reg <= sample.last_sample;
        end
        if (state_reg == CS_ACC && acc_done)
        begin
            sharpe_reg  <= '0;
            sortino_reg <= '0;
            rms_reg     <= '0;
        end
        if (state_reg == CS_CALC && launched_reg && unit_done)
        begin
            case (step_reg)
                ST_MEAN:
                begin
                    mm_reg    <= div_q[31:0];
                    m_neg_reg <= acc.return_sum[47];
                end
                ST_RFP:  rfp_reg     <= div_q[31:0];
                ST_MSQ:  mm2_reg     <= mul_p;
                ST_SUB:  sub_reg     <= mul_p;
                ST_DEV:  tmp_reg     <= div_q;
                ST_SD:   sd_reg      <= sqrt_root;
                ST_RP:   rootp_reg   <= sqrt_root;
                ST_LDIV: tmp_reg     <= div_q;
                ST_RMS:  rms_reg     <= sqrt_root;
                ST_NUM:  num_reg     <= mul_p;
                ST_QSH:  sharpe_reg  <= sat_q16(div_q, ex_neg);
                ST_QSO:  sortino_reg <= sat_q16(div_q, ex_neg);
                default: ;
            endcase
        end
        if (out_load)
        begin
            result_reg.sharpe_ratio   <= sharpe_reg;
            result_reg.sortino_ratio  <= sortino_reg;
            result_reg.samples_seen   <= 16'(acc.sample_total);
            result_reg.count_overflow <= acc.overflow_seen;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    `SSR_ASSERT_NEXT(a_accept_to_acc, sample_valid && sample_ready,
        state_reg == CS_ACC, "accepted beat did not start accumulation")
    `SSR_ASSERT_NOW(a_one_unit, 1'b1, $onehot0({div_busy, mul_busy, sqrt_busy}),
        "more than one back-end unit busy")
    `SSR_ASSERT_NEXT(a_load_valid, out_load, result_valid_reg,
        "result load did not raise valid")
    `SSR_ASSERT_NOW(a_no_take_busy, state_reg != CS_IDLE, !sample_ready,
        "sample taken while busy")
endmodule

// ===== verif/tb_sharpe_sortino_ratio.sv =====
// Self-checking testbench for the annualized Sharpe/Sortino ratio unit.
// Depends on ssr_pkg and the sharpe_sortino_ratio RTL; it predicts each result in-line.
`default_nettype none

module tb_sharpe_sortino_ratio;
    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    localparam int  DRAIN_CYCLES = 700;
    localparam int  HOLD_CYCLES  = 3000;
    localparam longint CYCLE_LIMIT = 8_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    in_beat_t    sample = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    out_beat_t   result;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_RISK_FREE;
    logic [31:0] cfg_data = '0;

    sharpe_sortino_ratio dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of registers and accumulators
    longint            rf_annual;
    logic [15:0]       periods;
    logic [15:0]       tally;
    longint            ret_sum;
    longint unsigned   sq_sum;
    logic [15:0]       loss_tally;
    longint unsigned   loss_sq_sum;
    bit                dropped;

    out_beat_t pending_ratios[$];

    int  mismatches = 0;
    int  results_checked = 0;
    int  items_sent = 0;
    int  cfg_writes = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    longint cycles = 0;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] scaled_ratio(longint excess, longint unsigned dev,
                                                 longint unsigned root_p);
        longint unsigned mag;
        longint unsigned q;
        if (dev == 0)
            return '0;
        mag = excess < 0 ? longint'(-excess) : excess;
        q = (mag * root_p) / (dev << 8);
        if (excess < 0)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    task automatic clear_series();
        tally = '0;
        ret_sum = 0;
        sq_sum = 0;
        loss_tally = '0;
        loss_sq_sum = 0;
        dropped = 1'b0;
    endtask

    // fold one accepted beat into the running series, queue a result on last
    task automatic accumulate_return(in_beat_t b);
        longint          r;
        longint unsigned mag;
        longint unsigned sq;
        longint          n;
        longint          p;
        longint          m;
        longint          excess;
        longint unsigned mm;
        longint unsigned sub;
        longint unsigned devsq;
        longint unsigned sd;
        longint unsigned root_p;
        longint unsigned rms;
        out_beat_t       o;
        r = longint'(b.return_sample);
        if (tally == COUNT_LIMIT)
            dropped = 1'b1;
        else
        begin
            mag = r < 0 ? longint'(-r) : r;
            sq = (mag * mag) >> 16;
            tally++;
            ret_sum += r;
            sq_sum += sq;
            if (r < 0)
            begin
                loss_tally++;
                loss_sq_sum += sq;
            end
        end
        if (!b.last_sample)
            return;
        o = '0;
        if (tally >= 2)
        begin
            n = longint'(tally);
            p = periods == 0 ? 1 : longint'(periods);
            m = ret_sum / n;
            excess = m - rf_annual / p;
            mm = m < 0 ? longint'(-m) : m;
            sub = longint'(n) * ((mm * mm) >> 16);
            devsq = sq_sum > sub ? sq_sum - sub : 0;
            sd = isqrt(devsq / longint'(n - 1));
            root_p = isqrt(longint'(p) << 32);
            rms = 0;
            if (loss_tally != 0)
                rms = isqrt(loss_sq_sum / longint'(loss_tally));
            o.sharpe_ratio = scaled_ratio(excess, sd, root_p);
            o.sortino_ratio = scaled_ratio(excess, rms, root_p);
        end
        o.samples_seen = tally;
        o.count_overflow = dropped;
        pending_ratios = {pending_ratios, o};
        clear_series();
    endtask

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_return(logic signed [31:0] value, logic last);
        int gap;
        in_beat_t b;
        gap = pick_gap();
        b.return_sample = value;
        b.last_sample = last;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= b;
        do
            @(posedge clk);
        while (!sample_ready);
        accumulate_return(b);
        items_sent++;
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_ratios.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // caller drops cfg_we after the last write
    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == CFG_RISK_FREE)
            rf_annual = longint'(signed'(value));
        else
            periods = value[15:0];
        cfg_writes++;
    endtask

    task automatic set_rates(logic [31:0] rf, logic [31:0] per);
        wait_idle();
        write_reg(CFG_RISK_FREE, rf);
        write_reg(CFG_PERIODS, per);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_return();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0200_0000);
            2: return -$signed($urandom_range(0, 32'h0200_0000));
            3: return $signed($urandom_range(0, 2000)) - 1000;
            4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        endcase
    endfunction

    task automatic send_series(int len, logic signed [31:0] fixed, bit use_fixed);
        for (int i = 0; i < len; i++)
            send_return(use_fixed ? fixed : rand_return(), i == len - 1);
    endtask

    task automatic test_directed();
        // single-sample series, both extremes
        send_series(1, 32'sh7FFF_FFFF, 1);
        send_series(1, 32'sh8000_0000, 1);
        // constant series: zero deviation, both full-scale extremes and zero
        send_series(3, 32'sh7FFF_FFFF, 1);
        send_series(2, 32'sh8000_0000, 1);
        send_series(2, 32'sh0, 1);
        // all gains, no losses
        send_return(32'sh0100_0000, 1'b0);
        send_return(32'sh0180_0000, 1'b1);
        // near-constant large gain: positive saturation
        send_return(32'sh7FFF_FFFF, 1'b0);
        send_return(32'sh7FFF_FFFE, 1'b1);
        set_rates(32'h8000_0000, 32'd65535);
        send_return(32'sh8000_0000, 1'b0);
        send_return(32'sh8000_0001, 1'b0);
        send_return(32'sh7FFF_FFFF, 1'b1);
        // zero periods behaves as one, max risk-free rate
        set_rates(32'h7FFF_FFFF, 32'd0);
        send_return(-32'sd1, 1'b0);
        send_return(32'sd1, 1'b1);
        send_return(32'sh8000_0000, 1'b0);
        send_return(32'sh0000_0001, 1'b1);
        set_rates(32'h0000_0000, 32'd1);
        send_series(4, 32'sh0, 0);
    endtask

    task automatic test_random();
        int len;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: set_rates($urandom(), $urandom_range(1, 65535));
                1: set_rates($urandom_range(0, 32'h0020_0000), 32'd252);
                2: set_rates(phase < 4 ? 32'h7FFF_FFFF : 32'h8000_0000, 32'd1);
                default: set_rates($urandom(), $urandom() | 32'hFFFF_0000);
            endcase
            calm = (phase == 3);
            while (items_sent < 90 * (phase + 1) + 30)
            begin
                case ($urandom_range(0, 9))
                    0: len = 1;
                    1: len = $urandom_range(10, 40);
                    default: len = $urandom_range(2, 8);
                endcase
                send_series(len, rand_return(), $urandom_range(0, 7) == 0);
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_req = 1'b1;
        // results pile up behind the stalled output until input stalls too
        for (int s = 0; s < 6; s++)
            send_series(2, rand_return(), 0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (calm)
            result_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 3)
        begin
            result_ready <= 1'b0;
            hold_left = $urandom_range(10, 60);
        end
        else
            result_ready <= $urandom_range(0, 99) < 70;
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_ratios.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", result);
            end
            else
            begin
                want = pending_ratios.pop_front();
                results_checked++;
                if (result.sharpe_ratio !== want.sharpe_ratio
                    || result.sortino_ratio !== want.sortino_ratio
                    || result.samples_seen !== want.samples_seen
                    || result.count_overflow !== want.count_overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected sharpe %0d sortino %0d n %0d ovf %0b,",
                                 want.sharpe_ratio, want.sortino_ratio,
                                 want.samples_seen, want.count_overflow);
                        $display("          got sharpe %0d sortino %0d n %0d ovf %0b",
                                 result.sharpe_ratio, result.sortino_ratio,
                                 result.samples_seen, result.count_overflow);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[sharpe_sortino_ratio] ERROR");
            $finish;
        end
    end

    initial
    begin
        rf_annual = 0;
        periods = PERIODS_RESET;
        clear_series();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_idle();
        $display("covered %0d samples, %0d series checked, %0d register writes,",
                 items_sent, results_checked, cfg_writes);
        $display("including extreme returns, zero periods and a long output stall");
        if (mismatches == 0 && pending_ratios.size() == 0)
            $display("[sharpe_sortino_ratio] OK");
        else
            $display("[sharpe_sortino_ratio] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
